@@ rtl/pump_tower_rotation_sequencer_macros.svh @@
// assertion macros for the pump tower rotation sequencer
`ifndef PUMP_TOWER_ROTATION_SEQUENCER_MACROS_SVH
`define PUMP_TOWER_ROTATION_SEQUENCER_MACROS_SVH
`ifndef SYNTH
`define PTRS_ASSERT_SAME(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptrs same-cycle assertion failed");
`define PTRS_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptrs next-cycle assertion failed");
`else
`define PTRS_ASSERT_SAME(label, clock, rst_n, ante, cons)
`define PTRS_ASSERT_NEXT(label, clock, rst_n, ante, cons)
`endif
`endif

@@ rtl/ptrs_pkg.sv @@
// shared types and constants of the pump tower rotation sequencer
package ptrs_pkg;

	localparam int NUM_TOWERS        = 8;
	localparam int MAX_RETRY         = 3;
	localparam int MAX_FAILED_TOWERS = 3;
	localparam int SEC_PER_MIN       = 60;

	// seconds from which the minutes display saturates
	localparam logic [31:0] MIN_SAT_SECONDS = 32'(65536 * SEC_PER_MIN);
	// minutes = (seconds / 4) / 15, the / 15 by reciprocal
	localparam int          RECIP_SHIFT = 24;
	localparam logic [20:0] RECIP_15    = 21'((64'd1 << RECIP_SHIFT) / 15 + 1);

	localparam logic [2:0] REG_TOWER_MASK = 3'd0;
	localparam logic [2:0] REG_NO_FLOW    = 3'd1;
	localparam logic [2:0] REG_COOLDOWN   = 3'd2;
	localparam logic [2:0] REG_RUN_LOW    = 3'd3;
	localparam logic [2:0] REG_RUN_HIGH   = 3'd4;

	typedef enum logic [2:0] {
		PH_INIT       = 3'd0,
		PH_SELECT     = 3'd1,
		PH_ENABLE     = 3'd2,
		PH_CHECK_PUMP = 3'd3,
		PH_CHECK_FLOW = 3'd4,
		PH_COOLDOWN   = 3'd5,
		PH_RUNNING    = 3'd6,
		PH_ERROR      = 3'd7
	} phase_t;

	typedef struct packed {
		logic [7:0]  tower_enable_mask;
		logic [15:0] no_flow_limit_seconds;
		logic [15:0] cooldown_limit_seconds;
		logic [63:0] run_minutes_low_towers;
		logic [63:0] run_minutes_high_towers;
	} cfg_t;

	typedef struct packed {
		logic [15:0] seconds_sat;
		logic [15:0] minutes_sat;
	} elapsed_t;

endpackage

@@ rtl/ptrs_if.sv @@
// item channels of the pump tower rotation sequencer
interface ptrs_tick_if;
	logic        valid;
	logic        ready;
	logic        run_enable;
	logic        pump_feedback;
	logic        flow_present;
	logic [31:0] seconds_now;

	modport source (output valid, run_enable, pump_feedback, flow_present, seconds_now,
		input ready);
	modport sink (input valid, run_enable, pump_feedback, flow_present, seconds_now,
		output ready);
endinterface

interface ptrs_result_if;
	logic        valid;
	logic        ready;
	logic        pump_on;
	logic [7:0]  tower_drive;
	logic [3:0]  active_tower_number;
	logic [15:0] no_flow_seconds;
	logic [15:0] cooldown_seconds;
	logic [15:0] run_minutes;
	logic [2:0]  phase;

	modport source (output valid, pump_on, tower_drive, active_tower_number,
		no_flow_seconds, cooldown_seconds, run_minutes, phase, input ready);
	modport sink (input valid, pump_on, tower_drive, active_tower_number,
		no_flow_seconds, cooldown_seconds, run_minutes, phase, output ready);
endinterface

@@ rtl/ptrs_cfg.sv @@
// configuration registers behind the apb port
module ptrs_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [5:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	output ptrs_pkg::cfg_t    cfg
);

	ptrs_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[5:3];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tower_enable_mask       <= '0;
			cfg_q.no_flow_limit_seconds   <= 16'(ptrs_pkg::SEC_PER_MIN);
			cfg_q.cooldown_limit_seconds  <= 16'(ptrs_pkg::SEC_PER_MIN);
			cfg_q.run_minutes_low_towers  <= '0;
			cfg_q.run_minutes_high_towers <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				ptrs_pkg::REG_TOWER_MASK: cfg_q.tower_enable_mask <= pwdata[7:0];
				ptrs_pkg::REG_NO_FLOW:    cfg_q.no_flow_limit_seconds <= pwdata[15:0];
				ptrs_pkg::REG_COOLDOWN:   cfg_q.cooldown_limit_seconds <= pwdata[15:0];
				ptrs_pkg::REG_RUN_LOW:    cfg_q.run_minutes_low_towers <= pwdata;
				ptrs_pkg::REG_RUN_HIGH:   cfg_q.run_minutes_high_towers <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ptrs_pkg::REG_TOWER_MASK: prdata = {56'd0, cfg_q.tower_enable_mask};
			ptrs_pkg::REG_NO_FLOW:    prdata = {48'd0, cfg_q.no_flow_limit_seconds};
			ptrs_pkg::REG_COOLDOWN:   prdata = {48'd0, cfg_q.cooldown_limit_seconds};
			ptrs_pkg::REG_RUN_LOW:    prdata = cfg_q.run_minutes_low_towers;
			ptrs_pkg::REG_RUN_HIGH:   prdata = cfg_q.run_minutes_high_towers;
			default:                  prdata = '0;
		endcase
	end

endmodule

@@ rtl/ptrs_timer.sv @@
// elapsed seconds and minutes since the start stamp, saturated to 16 bits
module ptrs_timer (
	input  logic [31:0]        now,
	input  logic [31:0]        stamp,
	output ptrs_pkg::elapsed_t elapsed
);

	logic [31:0] diff;
	logic [19:0] quarters;
	logic [40:0] product;

	assign diff     = now - stamp;
	assign quarters = diff[21:2];
	assign product  = {21'd0, quarters} * {20'd0, ptrs_pkg::RECIP_15};

	assign elapsed.seconds_sat = (diff[31:16] != 16'd0) ? 16'hffff : diff[15:0];
	assign elapsed.minutes_sat = (diff >= ptrs_pkg::MIN_SAT_SECONDS) ? 16'hffff
		: product[ptrs_pkg::RECIP_SHIFT +: 16];

endmodule

@@ rtl/pump_tower_rotation_sequencer.sv @@
// pump tower rotation sequencer: top level with tick register and state logic
// a tick item is held in the tick register, and its result is loaded into the state registers when that item advances
// throughput: one item per cycle while results are accepted, set by the single state update per tick
// an unaccepted result stalls the tick register, which then holds one item
// reset: asynchronous, phase init, no tower, counters and displays zero,
// mask zero, both limits 60 s, run times zero
module pump_tower_rotation_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	ptrs_tick_if.sink     tick,
	ptrs_result_if.source result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [5:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);

	`include "pump_tower_rotation_sequencer_macros.svh"

	ptrs_pkg::cfg_t     cfg;
	ptrs_pkg::elapsed_t elapsed;

	logic        valid_s1;
	logic        run_s1;
	logic        fb_s1;
	logic        flow_s1;
	logic [31:0] now_s1;
	logic        res_valid_q;
	logic        adv;

	ptrs_pkg::phase_t phase_q, phase_d;
	logic [2:0]  cur_q, cur_d;
	logic        cur_vld_q, cur_vld_d;
	logic [7:0]  retry_q, retry_d;
	logic [7:0]  fail_q, fail_d;
	logic [31:0] start_q, start_d;
	logic        pump_q, pump_d;
	logic [7:0]  tower_q, tower_d;
	logic [15:0] nf_disp_q, nf_disp_d;
	logic [15:0] cd_disp_q, cd_disp_d;
	logic [15:0] min_disp_q, min_disp_d;
	logic [3:0]  num_q, num_d;

	logic [3:0]  sel_res;
	logic [15:0] nf_elapsed;
	logic [15:0] run_limit;
	logic [7:0]  retry_inc;
	logic [7:0]  fail_inc;

	ptrs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ptrs_timer u_timer (
		.now     (now_s1),
		.stamp   (start_q),
		.elapsed (elapsed)
	);

	// first enabled tower above the current one, from tower 0 if none or it is the last, else no wrap; msb is found flag
	function automatic logic [3:0] find_tower(input logic [7:0] mask, input logic [2:0] cur,
		input logic vld);
		logic [3:0] start;
		logic [3:0] res;
		start = vld ? ({1'b0, cur} + 4'd1) : 4'd0;
		if (start >= 4'(ptrs_pkg::NUM_TOWERS))
			start = 4'd0;
		res = 4'd0;
		for (int i = ptrs_pkg::NUM_TOWERS - 1; i >= 0; i--) begin
			if (mask[i] && (4'(i) >= start))
				res = {1'b1, 3'(i)};
		end
		return res;
	endfunction

	assign adv        = valid_s1 & (~res_valid_q | result.ready);
	assign tick.ready = ~valid_s1 | adv;

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			run_s1  <= tick.run_enable;
			fb_s1   <= tick.pump_feedback;
			flow_s1 <= tick.flow_present;
			now_s1  <= tick.seconds_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (tick.valid && tick.ready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	assign nf_elapsed = flow_s1 ? 16'd0 : elapsed.seconds_sat;
	assign run_limit  = cur_q[2] ? cfg.run_minutes_high_towers[{cur_q[1:0], 4'd0} +: 16]
		: cfg.run_minutes_low_towers[{cur_q[1:0], 4'd0} +: 16];
	assign retry_inc  = retry_q + 8'd1;
	assign fail_inc   = fail_q + 8'd1;

	always_comb begin
		phase_d    = phase_q;
		cur_d      = cur_q;
		cur_vld_d  = cur_vld_q;
		retry_d    = retry_q;
		fail_d     = fail_q;
		start_d    = start_q;
		pump_d     = pump_q;
		tower_d    = tower_q;
		nf_disp_d  = nf_disp_q;
		cd_disp_d  = cd_disp_q;
		min_disp_d = min_disp_q;
		num_d      = num_q;
		sel_res    = find_tower(cfg.tower_enable_mask, cur_q,
			cur_vld_q && (phase_q != ptrs_pkg::PH_INIT));
		if (!run_s1) begin
			phase_d = ptrs_pkg::PH_INIT;
		end else begin
			case (phase_q)
				ptrs_pkg::PH_INIT, ptrs_pkg::PH_SELECT: begin
					if (phase_q == ptrs_pkg::PH_INIT) begin
						fail_d     = 8'd0;
						start_d    = 32'd0;
						nf_disp_d  = 16'd0;
						cd_disp_d  = 16'd0;
						min_disp_d = 16'd0;
						num_d      = 4'd0;
						retry_d    = 8'd0;
					end
					cur_vld_d = sel_res[3];
					cur_d     = sel_res[2:0];
					if (sel_res[3]) begin
						retry_d = 8'd0;
						phase_d = ptrs_pkg::PH_ENABLE;
					end else begin
						phase_d = ptrs_pkg::PH_INIT;
					end
				end
				ptrs_pkg::PH_ENABLE: begin
					phase_d    = ptrs_pkg::PH_CHECK_PUMP;
					tower_d    = 8'd1 << cur_q;
					pump_d     = 1'b1;
					nf_disp_d  = 16'd0;
					cd_disp_d  = 16'd0;
					min_disp_d = 16'd0;
					num_d      = {1'b0, cur_q} + 4'd1;
				end
				ptrs_pkg::PH_CHECK_PUMP: begin
					if (fb_s1) begin
						phase_d = ptrs_pkg::PH_CHECK_FLOW;
						start_d = now_s1;
					end
				end
				ptrs_pkg::PH_CHECK_FLOW: begin
					if (flow_s1) begin
						phase_d = ptrs_pkg::PH_RUNNING;
						fail_d  = 8'd0;
						start_d = now_s1;
					end
					nf_disp_d = nf_elapsed;
					if (nf_elapsed >= cfg.no_flow_limit_seconds) begin
						phase_d = ptrs_pkg::PH_COOLDOWN;
						pump_d  = 1'b0;
						start_d = now_s1;
					end
				end
				ptrs_pkg::PH_COOLDOWN: begin
					cd_disp_d = elapsed.seconds_sat;
					if (elapsed.seconds_sat >= cfg.cooldown_limit_seconds) begin
						retry_d = retry_inc;
						if (8'(ptrs_pkg::MAX_RETRY) > retry_inc) begin
							phase_d = ptrs_pkg::PH_ENABLE;
						end else begin
							fail_d = fail_inc;
							if (8'(ptrs_pkg::MAX_FAILED_TOWERS) > fail_inc)
								phase_d = ptrs_pkg::PH_SELECT;
							else
								phase_d = ptrs_pkg::PH_ERROR;
						end
					end
				end
				ptrs_pkg::PH_RUNNING: begin
					min_disp_d = elapsed.minutes_sat;
					if (elapsed.minutes_sat >= run_limit) begin
						phase_d = ptrs_pkg::PH_SELECT;
						pump_d  = 1'b0;
						tower_d = 8'd0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ptrs_pkg::PH_INIT;
			cur_q      <= 3'd0;
			cur_vld_q  <= 1'b0;
			retry_q    <= 8'd0;
			fail_q     <= 8'd0;
			start_q    <= 32'd0;
			pump_q     <= 1'b0;
			tower_q    <= 8'd0;
			nf_disp_q  <= 16'd0;
			cd_disp_q  <= 16'd0;
			min_disp_q <= 16'd0;
			num_q      <= 4'd0;
		end else if (adv) begin
			phase_q    <= phase_d;
			cur_q      <= cur_d;
			cur_vld_q  <= cur_vld_d;
			retry_q    <= retry_d;
			fail_q     <= fail_d;
			start_q    <= start_d;
			pump_q     <= pump_d;
			tower_q    <= tower_d;
			nf_disp_q  <= nf_disp_d;
			cd_disp_q  <= cd_disp_d;
			min_disp_q <= min_disp_d;
			num_q      <= num_d;
		end
	end

	// state only moves when a result is loaded, so it doubles as the result register
	assign result.valid               = res_valid_q;
	assign result.pump_on             = pump_q;
	assign result.tower_drive         = tower_q;
	assign result.active_tower_number = num_q;
	assign result.no_flow_seconds     = nf_disp_q;
	assign result.cooldown_seconds    = cd_disp_q;
	assign result.run_minutes         = min_disp_q;
	assign result.phase               = phase_q;

	`PTRS_ASSERT_SAME(a_tower_onehot, clk, arst_n, 1'b1, $onehot0(tower_q))
	`PTRS_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, res_valid_q && !result.ready,
		$stable(phase_q) && $stable(start_q) && res_valid_q)
	`PTRS_ASSERT_NEXT(a_error_latched, clk, arst_n,
		adv && run_s1 && (phase_q == ptrs_pkg::PH_ERROR), phase_q == ptrs_pkg::PH_ERROR)
	`PTRS_ASSERT_NEXT(a_run_drop_init, clk, arst_n, adv && !run_s1,
		phase_q == ptrs_pkg::PH_INIT && $stable(tower_q) && $stable(pump_q))

endmodule
